>>> hdl/vtt_pkg.sv
// Shared types and constants for the brace-structured text tokeniser.
`timescale 1ns / 1ps

package vtt_pkg;

    localparam int MAX_EVENTS = 5;

    localparam logic [2:0] EV_START = 3'd0;
    localparam logic [2:0] EV_CHAR  = 3'd1;
    localparam logic [2:0] EV_END   = 3'd2;
    localparam logic [2:0] EV_OPEN  = 3'd3;
    localparam logic [2:0] EV_CLOSE = 3'd4;
    localparam logic [2:0] EV_EOI   = 3'd5;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } text_word_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] out_char;
        logic       run_last;
    } event_word_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] chr;
    } ev_t;

    typedef struct packed {
        logic [2:0]                 count;
        ev_t [MAX_EVENTS-1:0]       ev;
    } bundle_t;

endpackage

>>> hdl/vtt_front.sv
// Front end: accepts text bytes, tracks the lexer mode and builds each byte's event bundle.
`timescale 1ns / 1ps

module vtt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  vtt_pkg::text_word_t text_word,
    input  logic                full,
    output logic                push,
    output vtt_pkg::bundle_t    push_bundle
);
    import vtt_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_SLASH   = 6'b000010,
        MODE_COMMENT = 6'b000100,
        MODE_BARE    = 6'b001000,
        MODE_QUOTED  = 6'b010000,
        MODE_ESC     = 6'b100000
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  accept;

    function automatic bundle_t add_ev(bundle_t b, logic [2:0] kind, logic [7:0] ch);
        bundle_t r;
        r = b;
        if (b.count < 3'(MAX_EVENTS))
        begin
            r.ev[b.count].kind = kind;
            r.ev[b.count].chr  = (kind == EV_CHAR) ? ch : 8'd0;
            r.count            = b.count + 3'd1;
        end
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    assign text_stall = full;
    assign accept     = text_valid && !full;

    always_comb
    begin
        logic [7:0] c;
        logic       fin;
        logic       run_bare;
        logic       run_idle;
        bundle_t    b;

        c        = text_word.char_code;
        fin      = text_word.final_char;
        run_bare = 1'b0;
        run_idle = 1'b0;
        b        = '0;
        mode_next = mode_reg;

        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (c == CH_QUOTE && fin)
                begin
                    b = add_ev(b, EV_START, 8'd0);
                    b = add_ev(b, EV_CHAR, CH_SLASH);
                    b = add_ev(b, EV_END, 8'd0);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    b = add_ev(b, EV_START, 8'd0);
                    b = add_ev(b, EV_CHAR, CH_SLASH);
                    mode_next = MODE_BARE;
                    run_bare  = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (c == CH_LF)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_BARE:
            begin
                run_bare = 1'b1;
            end
            MODE_QUOTED:
            begin
                if (c == CH_BSLASH)
                begin
                    if (fin)
                    begin
                        b = add_ev(b, EV_CHAR, CH_BSLASH);
                    end
                    else
                    begin
                        mode_next = MODE_ESC;
                    end
                end
                else if (c == CH_QUOTE)
                begin
                    b = add_ev(b, EV_END, 8'd0);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    b = add_ev(b, EV_CHAR, c);
                end
            end
            MODE_ESC:
            begin
                if (c == CH_QUOTE || c == CH_BSLASH)
                begin
                    b = add_ev(b, EV_CHAR, c);
                end
                else if (c == CH_LOWER_N)
                begin
                    b = add_ev(b, EV_CHAR, CH_LF);
                end
                else if (c == CH_LOWER_T)
                begin
                    b = add_ev(b, EV_CHAR, CH_TAB);
                end
                else
                begin
                    b = add_ev(b, EV_CHAR, CH_BSLASH);
                    b = add_ev(b, EV_CHAR, c);
                end
                mode_next = MODE_QUOTED;
            end
            default:
            begin
                mode_next = MODE_IDLE;
                run_idle  = 1'b1;
            end
        endcase

        if (run_bare)
        begin
            if (is_ws(c) || c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE)
            begin
                b = add_ev(b, EV_END, 8'd0);
                mode_next = MODE_IDLE;
                run_idle  = 1'b1;
            end
            else
            begin
                b = add_ev(b, EV_CHAR, c);
            end
        end

        if (run_idle && !is_ws(c))
        begin
            priority if (c == CH_LBRACE)
            begin
                b = add_ev(b, EV_OPEN, 8'd0);
            end
            else if (c == CH_RBRACE)
            begin
                b = add_ev(b, EV_CLOSE, 8'd0);
            end
            else if (c == CH_QUOTE)
            begin
                b = add_ev(b, EV_START, 8'd0);
                mode_next = MODE_QUOTED;
            end
            else if (c == CH_SLASH)
            begin
                mode_next = MODE_SLASH;
            end
            else
            begin
                b = add_ev(b, EV_START, 8'd0);
                b = add_ev(b, EV_CHAR, c);
                mode_next = MODE_BARE;
            end
        end

        if (fin)
        begin
            if (mode_next == MODE_BARE || mode_next == MODE_QUOTED || mode_next == MODE_ESC)
            begin
                b = add_ev(b, EV_END, 8'd0);
            end
            else if (mode_next == MODE_SLASH)
            begin
                b = add_ev(b, EV_START, 8'd0);
                b = add_ev(b, EV_CHAR, CH_SLASH);
                b = add_ev(b, EV_END, 8'd0);
            end
            b = add_ev(b, EV_EOI, 8'd0);
            mode_next = MODE_IDLE;
        end

        push_bundle = b;
    end

    assign push = accept && (push_bundle.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

>>> hdl/vtt_queue.sv
// Short bundle queue between the front and back ends.
`timescale 1ns / 1ps

module vtt_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vtt_pkg::bundle_t push_bundle,
    output logic             full,
    input  logic             pop,
    output vtt_pkg::bundle_t head,
    output logic             empty
);
    import vtt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/vtt_back.sv
// Back end: walks each queued bundle and issues one event word per cycle while event_stall is low.
`timescale 1ns / 1ps

module vtt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vtt_pkg::bundle_t     head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 event_valid,
    input  logic                 event_stall,
    output vtt_pkg::event_word_t event_word
);
    import vtt_pkg::*;

    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        valid_reg;
    logic        valid_next;
    event_word_t word_reg;
    event_word_t word_next;
    logic        load;
    logic        last;
    ev_t         cur;

    assign load = !empty && (!valid_reg || !event_stall);
    assign cur  = head.ev[idx_reg];
    assign last = (idx_reg == head.count - 3'd1);
    assign pop  = load && last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && event_stall;
        word_next  = word_reg;
        if (load)
        begin
            valid_next           = 1'b1;
            word_next.event_kind = cur.kind;
            word_next.out_char   = cur.chr;
            word_next.run_last   = last;
            idx_next             = last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign event_valid = valid_reg;
    assign event_word  = word_reg;

endmodule

>>> hdl/vdf_text_tokenizer.sv
// Top level of the brace-structured key/value text tokeniser.
`timescale 1ns / 1ps

// Takes one text byte per word and returns its lexical events (string start,
// string character, string end, open brace, close brace, end of input), one
// event per word, with run_last set on the final event of each byte. The front
// end accepts one byte every cycle while the bundle queue has room; a byte
// yields zero to five events, and the back end issues one event per cycle from
// its output register while event_stall is low, and bytes giving no event are
// never queued. The first event of a byte is written into the bundle queue and
// then into the back end's output register before it is presented.
module vdf_text_tokenizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  vtt_pkg::text_word_t  text_word,
    output logic                 event_valid,
    input  logic                 event_stall,
    output vtt_pkg::event_word_t event_word
);
    import vtt_pkg::*;

    logic    full;
    logic    empty;
    logic    push;
    logic    pop;
    bundle_t push_bundle;
    bundle_t head;

    vtt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_word   (text_word),
        .full        (full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    vtt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (full),
        .pop         (pop),
        .head        (head),
        .empty       (empty)
    );

    vtt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word)
    );

endmodule

>>> tb/sv/tb_vdf_text_tokenizer.sv
// Self-checking testbench for the brace-structured text tokeniser.
`timescale 1ns / 1ps

module tb_vdf_text_tokenizer;

    import vtt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_SLASH,
        LX_COMMENT,
        LX_BARE,
        LX_QUOTED,
        LX_ESC
    } lex_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        text_valid = 1'b0;
    logic        text_stall;
    text_word_t  text_word = '0;
    logic        event_valid;
    logic        event_stall = 1'b0;
    event_word_t event_word;

    text_word_t  text_backlog[$];
    event_word_t events_due[$];
    event_word_t byte_events[$];
    lex_mode_e   lex_mode = LX_IDLE;

    int unsigned bytes_taken = 0;
    int unsigned docs_done = 0;
    int unsigned events_checked = 0;
    int unsigned errors = 0;
    int unsigned drv_gap_left = 0;
    int unsigned drv_calm = 0;
    int unsigned stall_left = 0;
    int unsigned mon_calm = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned quiet_cycles = 0;

    vdf_text_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_word   (text_word),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void note(logic [2:0] kind, logic [7:0] c);
        event_word_t ev;
        if (byte_events.size() < MAX_EVENTS)
        begin
            ev.event_kind = kind;
            ev.out_char   = (kind == EV_CHAR) ? c : 8'h00;
            ev.run_last   = 1'b0;
            byte_events.push_back(ev);
        end
    endfunction

    function automatic void lex_idle(logic [7:0] c);
        if (c == CH_LBRACE)
            note(EV_OPEN, 8'h00);
        else if (c == CH_RBRACE)
            note(EV_CLOSE, 8'h00);
        else if (c == CH_QUOTE)
        begin
            note(EV_START, 8'h00);
            lex_mode = LX_QUOTED;
        end
        else if (c == CH_SLASH)
            lex_mode = LX_SLASH;
        else if (!is_space(c))
        begin
            note(EV_START, 8'h00);
            note(EV_CHAR, c);
            lex_mode = LX_BARE;
        end
    endfunction

    function automatic void lex_bare(logic [7:0] c);
        if (is_space(c) || c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE)
        begin
            note(EV_END, 8'h00);
            lex_mode = LX_IDLE;
            lex_idle(c);
        end
        else
            note(EV_CHAR, c);
    endfunction

    function automatic void tokenise_byte(text_word_t w);
        logic [7:0]  c;
        bit          fin;
        event_word_t ev;
        c   = w.char_code;
        fin = w.final_char;
        byte_events.delete();
        case (lex_mode)
            LX_SLASH:
            begin
                if (c == CH_SLASH)
                    lex_mode = LX_COMMENT;
                else if (c == CH_QUOTE && fin)
                begin
                    note(EV_START, 8'h00);
                    note(EV_CHAR, CH_SLASH);
                    note(EV_END, 8'h00);
                    lex_mode = LX_IDLE;
                end
                else
                begin
                    note(EV_START, 8'h00);
                    note(EV_CHAR, CH_SLASH);
                    lex_mode = LX_BARE;
                    lex_bare(c);
                end
            end
            LX_COMMENT:
            begin
                if (c == CH_LF)
                    lex_mode = LX_IDLE;
            end
            LX_BARE:
                lex_bare(c);
            LX_QUOTED:
            begin
                if (c == CH_BSLASH)
                begin
                    if (fin)
                        note(EV_CHAR, CH_BSLASH);
                    else
                        lex_mode = LX_ESC;
                end
                else if (c == CH_QUOTE)
                begin
                    note(EV_END, 8'h00);
                    lex_mode = LX_IDLE;
                end
                else
                    note(EV_CHAR, c);
            end
            LX_ESC:
            begin
                if (c == CH_QUOTE || c == CH_BSLASH)
                    note(EV_CHAR, c);
                else if (c == CH_LOWER_N)
                    note(EV_CHAR, CH_LF);
                else if (c == CH_LOWER_T)
                    note(EV_CHAR, CH_TAB);
                else
                begin
                    note(EV_CHAR, CH_BSLASH);
                    note(EV_CHAR, c);
                end
                lex_mode = LX_QUOTED;
            end
            default:
            begin
                lex_mode = LX_IDLE;
                lex_idle(c);
            end
        endcase
        if (fin)
        begin
            if (lex_mode == LX_BARE || lex_mode == LX_QUOTED || lex_mode == LX_ESC)
                note(EV_END, 8'h00);
            else if (lex_mode == LX_SLASH)
            begin
                note(EV_START, 8'h00);
                note(EV_CHAR, CH_SLASH);
                note(EV_END, 8'h00);
            end
            note(EV_EOI, 8'h00);
            lex_mode = LX_IDLE;
        end
        if (byte_events.size() != 0)
        begin
            ev = byte_events.pop_back();
            ev.run_last = 1'b1;
            byte_events.push_back(ev);
        end
        foreach (byte_events[i])
            events_due.push_back(byte_events[i]);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    task automatic put_byte(logic [7:0] c, bit fin);
        text_word_t w;
        w.char_code  = c;
        w.final_char = fin;
        text_backlog.push_back(w);
    endtask

    task automatic end_document();
        text_word_t w;
        w = text_backlog.pop_back();
        w.final_char = 1'b1;
        text_backlog.push_back(w);
    endtask

    // Drive text words from the backlog
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned gap;
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_word  <= '0;
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                tokenise_byte(text_word);
                bytes_taken++;
                if (text_word.final_char)
                    docs_done++;
            end
            if (!(text_valid && text_stall))
            begin
                if (drv_gap_left > 0)
                begin
                    drv_gap_left--;
                    text_valid <= 1'b0;
                end
                else if (text_backlog.size() != 0)
                begin
                    text_valid <= 1'b1;
                    text_word  <= text_backlog.pop_front();
                    if (drv_calm > 0)
                    begin
                        drv_calm--;
                        gap = 0;
                    end
                    else
                    begin
                        gap = pick_gap();
                        if ($urandom_range(0, 29) == 0)
                            drv_calm = $urandom_range(15, 40);
                    end
                    drv_gap_left = gap;
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    // Check event words and drive stall
    always @(posedge clk or negedge rst_n)
    begin
        event_word_t due;
        logic        stall_next;
        int unsigned gap;
        if (!rst_n)
            event_stall <= 1'b0;
        else
        begin
            if (event_valid && !event_stall)
            begin
                events_checked++;
                if (events_due.size() == 0)
                begin
                    $display("%0t: unexpected event, got kind %0d char %02h last %0b",
                             $time, event_word.event_kind, event_word.out_char,
                             event_word.run_last);
                    errors++;
                end
                else
                begin
                    due = events_due.pop_front();
                    if (event_word.event_kind !== due.event_kind ||
                        event_word.out_char !== due.out_char ||
                        event_word.run_last !== due.run_last)
                    begin
                        $display("%0t: mismatch, expected %0d %02h %0b, got %0d %02h %0b",
                                 $time, due.event_kind, due.out_char, due.run_last,
                                 event_word.event_kind, event_word.out_char,
                                 event_word.run_last);
                        errors++;
                    end
                end
            end
            if (!hold_done && events_checked >= 30)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if (mon_calm > 0)
                begin
                    mon_calm--;
                    gap = 0;
                end
                else
                begin
                    gap = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        mon_calm = $urandom_range(15, 40);
                end
                stall_next = (gap > 0);
                if (gap > 0)
                    stall_left = gap - 1;
            end
            event_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(text_valid && !text_stall) && !(event_valid && !event_stall))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned tokens;
        int unsigned len;
        logic [7:0]  c;

        put_byte(CH_LBRACE, 1'b0);
        put_byte(CH_QUOTE, 1'b0);
        put_byte(CH_BSLASH, 1'b0);
        put_byte(CH_LOWER_N, 1'b0);
        put_byte(CH_BSLASH, 1'b0);
        put_byte(CH_LOWER_T, 1'b0);
        put_byte(CH_BSLASH, 1'b0);
        put_byte(CH_QUOTE, 1'b0);
        put_byte(CH_BSLASH, 1'b0);
        put_byte(CH_BSLASH, 1'b0);
        put_byte(CH_BSLASH, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(CH_QUOTE, 1'b0);
        put_byte(CH_RBRACE, 1'b1);
        put_byte(CH_SLASH, 1'b0);
        put_byte(CH_SLASH, 1'b0);
        put_byte(CH_LF, 1'b0);
        put_byte(CH_SLASH, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(CH_LBRACE, 1'b0);
        put_byte(CH_QUOTE, 1'b1);
        put_byte(CH_QUOTE, 1'b0);
        put_byte(CH_BSLASH, 1'b1);
        put_byte(CH_SLASH, 1'b1);
        put_byte(CH_SLASH, 1'b0);
        put_byte(CH_QUOTE, 1'b1);

        while (text_backlog.size() < 210)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                tokens = $urandom_range(1, 6);
                for (int k = 0; k < tokens; k++)
                begin
                    case ($urandom_range(0, 5))
                        0: put_byte(CH_LBRACE, 1'b0);
                        1: put_byte(CH_RBRACE, 1'b0);
                        2:
                        begin
                            put_byte(CH_QUOTE, 1'b0);
                            len = $urandom_range(0, 4);
                            for (int t = 0; t < len; t++)
                            begin
                                if ($urandom_range(0, 3) == 0)
                                begin
                                    put_byte(CH_BSLASH, 1'b0);
                                    case ($urandom_range(0, 4))
                                        0: c = CH_QUOTE;
                                        1: c = CH_BSLASH;
                                        2: c = CH_LOWER_N;
                                        3: c = CH_LOWER_T;
                                        default: c = 8'($urandom_range(0, 255));
                                    endcase
                                    put_byte(c, 1'b0);
                                end
                                else
                                begin
                                    do
                                        c = 8'($urandom_range(0, 255));
                                    while (c == CH_QUOTE || c == CH_BSLASH);
                                    put_byte(c, 1'b0);
                                end
                            end
                            if ($urandom_range(0, 9) != 0)
                                put_byte(CH_QUOTE, 1'b0);
                        end
                        3:
                        begin
                            len = $urandom_range(1, 4);
                            for (int t = 0; t < len; t++)
                            begin
                                do
                                    c = 8'($urandom_range(0, 255));
                                while (is_space(c) || c == CH_LBRACE || c == CH_RBRACE ||
                                       c == CH_QUOTE || (t == 0 && c == CH_SLASH));
                                put_byte(c, 1'b0);
                            end
                        end
                        4:
                        begin
                            put_byte(CH_SLASH, 1'b0);
                            put_byte(CH_SLASH, 1'b0);
                            len = $urandom_range(0, 3);
                            for (int t = 0; t < len; t++)
                            begin
                                do
                                    c = 8'($urandom_range(0, 255));
                                while (c == CH_LF);
                                put_byte(c, 1'b0);
                            end
                            put_byte(CH_LF, 1'b0);
                        end
                        default:
                        begin
                            if ($urandom_range(0, 5) == 0)
                                put_byte(CH_SPACE, 1'b0);
                            else
                                put_byte(8'($urandom_range(9, 13)), 1'b0);
                        end
                    endcase
                    if ($urandom_range(0, 1) == 0)
                        put_byte(CH_SPACE, 1'b0);
                end
                end_document();
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int t = 0; t < len; t++)
                    put_byte(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1) == 0)
                    end_document();
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (text_backlog.size() != 0 || text_valid || events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Tokenised %0d bytes over %0d documents, escapes, comments and stalls included;",
                 bytes_taken, docs_done);
        $display("compared %0d events, %0d mismatched.", events_checked, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
